/* design/mtpd_pkg.sv */
// Shared types, constants and the letter table of the Morse tone-period decoder.
package mtpd_pkg;

    localparam int WINDOW_BITS        = 8;
    localparam int SYMBOLS_PER_LETTER = 5;
    localparam int SYM_COUNT_W        = $clog2(SYMBOLS_PER_LETTER + 1);

    localparam int COUNT_W  = 8;
    localparam int THR_W    = 8;
    localparam int SPP_W    = 6;
    localparam int CHAR_W   = 7;
    localparam int OFFSET_W = 10;
    localparam int MAG_W    = 12;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam logic [COUNT_W-1:0] TONE_COUNT_LIMIT = 8'd30;
    localparam logic [COUNT_W-1:0] JITTER_FLOOR     = 8'd12;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 8'd20;
    localparam logic [SPP_W-1:0]   SPP_RESET        = 6'd32;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h40;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

    localparam logic [2:0] SKIP_DOT      = 3'd1;
    localparam logic [2:0] SKIP_SOFT_DOT = 3'd2;
    localparam logic [2:0] SKIP_DASH     = 3'd3;
    localparam logic [2:0] SKIP_LETTER   = 3'd2;
    localparam logic [2:0] SKIP_WORD     = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_PERIOD = 8'd1;

    typedef enum logic [1:0] {
        SYM_EMPTY = 2'd0,
        SYM_DOT   = 2'd1,
        SYM_DASH  = 2'd2
    } sym_t;

    typedef logic [2*SYMBOLS_PER_LETTER-1:0] letter_key_t;

    // Per-period tone and timing information handed to the symbol decoder.
    typedef struct packed {
        logic                       tone_bit;
        logic                       top_heavy;
        logic signed [OFFSET_W-1:0] offset;
    } timing_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
    } char_out_t;

    // The first symbol of the letter sits in the top two bits of the key.
    function automatic logic [CHAR_W-1:0] decode_letter(input letter_key_t key);
        logic [7:0] ch;
        unique case (key)
            10'b01_10_00_00_00: ch = "A";
            10'b10_01_01_01_00: ch = "B";
            10'b10_01_10_01_00: ch = "C";
            10'b10_01_01_00_00: ch = "D";
            10'b01_00_00_00_00: ch = "E";
            10'b01_01_10_01_00: ch = "F";
            10'b10_10_01_00_00: ch = "G";
            10'b01_01_01_01_00: ch = "H";
            10'b01_01_00_00_00: ch = "I";
            10'b01_10_10_10_00: ch = "J";
            10'b10_01_10_00_00: ch = "K";
            10'b01_10_01_01_00: ch = "L";
            10'b10_10_00_00_00: ch = "M";
            10'b10_01_00_00_00: ch = "N";
            10'b10_10_10_00_00: ch = "O";
            10'b01_10_10_01_00: ch = "P";
            10'b10_10_01_10_00: ch = "Q";
            10'b01_10_01_00_00: ch = "R";
            10'b01_01_01_00_00: ch = "S";
            10'b10_00_00_00_00: ch = "T";
            10'b01_01_10_00_00: ch = "U";
            10'b01_01_01_10_00: ch = "V";
            10'b01_10_10_00_00: ch = "W";
            10'b10_01_01_10_00: ch = "X";
            10'b10_01_10_10_00: ch = "Y";
            10'b10_10_01_01_00: ch = "Z";
            10'b01_10_10_10_10: ch = "1";
            10'b01_01_10_10_10: ch = "2";
            10'b01_01_01_10_10: ch = "3";
            10'b01_01_01_01_10: ch = "4";
            10'b01_01_01_01_01: ch = "5";
            10'b10_01_01_01_01: ch = "6";
            10'b10_10_01_01_01: ch = "7";
            10'b10_10_10_01_01: ch = "8";
            10'b10_10_10_10_01: ch = "9";
            10'b10_10_10_10_10: ch = "0";
            10'b01_10_01_01_01: ch = "&";
            default:            ch = {1'b0, CHAR_UNKNOWN};
        endcase
        return ch[CHAR_W-1:0];
    endfunction

endpackage

/* design/morse_tone_period_decoder.sv */
// Morse tone-period decoder: the top level with its input, result and register stages.
//
// One item is one dot period's tone-match counts; every item gives exactly one result
// item carrying an optional character (letter, digit, '&', '@' for an unknown letter,
// or a space at a word gap) and the timing-correction offset for the next period.
// The block takes one item per clock cycle while s_tready is high. An accepted item
// is caught in the input register; the tone compare, the pattern table and the letter
// lookup, which are combinational, load the result register from it once that register
// is free. While a result waits, the input register takes one more item and then
// s_tready stays low until the result is taken. Registers: index 0 is presence_threshold
// (reset 20), index 1 is samples_per_period (reset 32); other indexes are ignored.
// Write them only while idle.
module morse_tone_period_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] match_count, [15:8] first_half_count, [23:16] second_half_count
    input  logic [mtpd_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] char_code, [16:7] period_offset, [23:17] zero
    output logic [mtpd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] char_valid
    output logic [mtpd_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mtpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                              in_valid_reg;
    logic [mtpd_pkg::COUNT_W-1:0]      in_count_reg;
    logic [mtpd_pkg::COUNT_W-1:0]      in_first_reg;
    logic [mtpd_pkg::COUNT_W-1:0]      in_second_reg;
    logic                              out_valid_reg;
    logic                              out_char_valid_reg;
    logic [mtpd_pkg::CHAR_W-1:0]       out_code_reg;
    logic signed [mtpd_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [mtpd_pkg::THR_W-1:0]        threshold_reg;
    logic [mtpd_pkg::SPP_W-1:0]        spp_reg;

    logic                 out_free;
    logic                 step;
    mtpd_pkg::timing_t    timing;
    mtpd_pkg::char_out_t  char_out;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    mtpd_timing u_timing (
        .match_count        (in_count_reg),
        .first_half_count   (in_first_reg),
        .second_half_count  (in_second_reg),
        .presence_threshold (threshold_reg),
        .samples_per_period (spp_reg),
        .timing             (timing)
    );

    mtpd_symbol_decoder u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .timing   (timing),
        .char_out (char_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= mtpd_pkg::THRESHOLD_RESET;
            spp_reg       <= mtpd_pkg::SPP_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mtpd_pkg::REG_PRESENCE_THRESHOLD) begin
                    threshold_reg <= cfg_data[mtpd_pkg::THR_W-1:0];
                end else if (cfg_index == mtpd_pkg::REG_SAMPLES_PER_PERIOD) begin
                    spp_reg <= cfg_data[mtpd_pkg::SPP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_count_reg  <= s_tdata[7:0];
            in_first_reg  <= s_tdata[15:8];
            in_second_reg <= s_tdata[23:16];
        end
        if (step) begin
            out_char_valid_reg <= char_out.char_valid;
            out_code_reg       <= char_out.char_code;
            out_offset_reg     <= timing.offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_offset_reg, out_code_reg};
    assign m_tuser  = out_char_valid_reg;

endmodule

/* design/mtpd_timing.sv */
// Tone detection and timing-correction offset for one dot period.
module mtpd_timing (
    input  logic [mtpd_pkg::COUNT_W-1:0] match_count,
    input  logic [mtpd_pkg::COUNT_W-1:0] first_half_count,
    input  logic [mtpd_pkg::COUNT_W-1:0] second_half_count,
    input  logic [mtpd_pkg::THR_W-1:0]   presence_threshold,
    input  logic [mtpd_pkg::SPP_W-1:0]   samples_per_period,
    output mtpd_pkg::timing_t            timing
);

    logic                        above_thr;
    logic                        late_tone;
    logic                        weak_tone;
    logic                        lead_first;
    logic [mtpd_pkg::MAG_W-1:0]  base;
    logic [mtpd_pkg::MAG_W-1:0]  mag;
    logic [mtpd_pkg::MAG_W-1:0]  signed_mag;

    always_comb begin
        above_thr  = match_count > presence_threshold;
        late_tone  = above_thr && (match_count < mtpd_pkg::TONE_COUNT_LIMIT);
        weak_tone  = !above_thr && (match_count > mtpd_pkg::JITTER_FLOOR);
        lead_first = first_half_count > second_half_count;

        // Short tone: correct by the missing frames; weak tone: by the frames seen.
        if (late_tone) begin
            base = {{(mtpd_pkg::MAG_W - mtpd_pkg::SPP_W){1'b0}}, samples_per_period}
                 - {{(mtpd_pkg::MAG_W - mtpd_pkg::COUNT_W){1'b0}}, match_count};
        end else begin
            base = {{(mtpd_pkg::MAG_W - mtpd_pkg::COUNT_W){1'b0}}, match_count};
        end
        // Times six as two shifted adds; the result wraps to the field width.
        mag        = (base << 2) + (base << 1);
        signed_mag = lead_first ? mag : (~mag + 1'b1);

        timing.tone_bit = above_thr;
        if (late_tone || weak_tone) begin
            timing.top_heavy = lead_first;
            timing.offset    = signed'(signed_mag[mtpd_pkg::OFFSET_W-1:0]);
        end else begin
            timing.top_heavy = 1'b0;
            timing.offset    = '0;
        end
    end

endmodule

/* design/mtpd_symbol_decoder.sv */
// Look-ahead window, pattern table, letter assembly and gap detection.
module mtpd_symbol_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  mtpd_pkg::timing_t    timing,
    output mtpd_pkg::char_out_t  char_out
);

    localparam int WB = mtpd_pkg::WINDOW_BITS;
    localparam int NS = mtpd_pkg::SYMBOLS_PER_LETTER;
    localparam int CW = mtpd_pkg::SYM_COUNT_W;

    logic [WB-1:0]       tone_window_reg, tone_window_next;
    logic                prev_bit_reg, prev_bit_next;
    logic                prev_prev_bit_reg, prev_prev_bit_next;
    logic [2:0]          skip_left_reg, skip_left_next;
    mtpd_pkg::sym_t      symbol_store_reg [NS];
    mtpd_pkg::sym_t      symbol_store_next [NS];
    logic [CW-1:0]       symbol_count_reg, symbol_count_next;
    logic                message_started_reg, message_started_next;
    logic                last_was_space_reg, last_was_space_next;
    logic                top_heavy_reg;

    logic [WB-1:0]           w;
    logic                    p1, p2, empty;
    logic                    add_en;
    mtpd_pkg::sym_t          add_sym;
    logic [2:0]              add_skip;
    mtpd_pkg::letter_key_t   key;

    always_comb begin
        tone_window_next   = {timing.tone_bit, tone_window_reg[WB-1:1]};
        prev_bit_next      = tone_window_reg[0];
        prev_prev_bit_next = prev_bit_reg;
        w  = tone_window_next;
        p1 = prev_bit_next;
        p2 = prev_prev_bit_next;

        empty = 1'b1;
        for (int i = 0; i < NS; i++) begin
            if (symbol_store_reg[i] != mtpd_pkg::SYM_EMPTY) begin
                empty = 1'b0;
            end
            key[2*(NS-1-i) +: 2] = symbol_store_reg[i];
        end

        skip_left_next       = skip_left_reg;
        symbol_store_next    = symbol_store_reg;
        symbol_count_next    = symbol_count_reg;
        message_started_next = message_started_reg;
        last_was_space_next  = last_was_space_reg;
        char_out.char_valid  = 1'b0;
        char_out.char_code   = mtpd_pkg::CHAR_NONE;
        add_en   = 1'b0;
        add_sym  = mtpd_pkg::SYM_DOT;
        add_skip = mtpd_pkg::SKIP_DOT;

        // Bit i of the window is look-ahead position i; the table is in priority order.
        if (skip_left_reg != 3'd0) begin
            skip_left_next = skip_left_reg - 3'd1;
        end else if (w[0] && !w[1]) begin
            add_en = 1'b1;
        end else if (w[0] && w[1] && w[2] && !w[3]) begin
            add_en = 1'b1; add_sym = mtpd_pkg::SYM_DASH; add_skip = mtpd_pkg::SKIP_DASH;
        end else if (!w[0] && !w[1] && !empty) begin
            char_out.char_valid  = 1'b1;
            char_out.char_code   = mtpd_pkg::decode_letter(key);
            skip_left_next       = mtpd_pkg::SKIP_LETTER;
            symbol_count_next    = '0;
            for (int i = 0; i < NS; i++) begin
                symbol_store_next[i] = mtpd_pkg::SYM_EMPTY;
            end
            message_started_next = 1'b1;
            last_was_space_next  = 1'b0;
        end else if (!p1 && (w[5:0] == 6'b000000) && message_started_reg) begin
            // A repeated word gap is absorbed here without a second space.
            if (!last_was_space_reg) begin
                char_out.char_valid = 1'b1;
                char_out.char_code  = mtpd_pkg::CHAR_SPACE;
                skip_left_next      = mtpd_pkg::SKIP_WORD;
                symbol_count_next   = '0;
                last_was_space_next = 1'b1;
            end
        end else if (!p1 && !w[0] && w[1] && w[2] && !w[3] && top_heavy_reg) begin
            add_en = 1'b1; add_sym = mtpd_pkg::SYM_DASH; add_skip = mtpd_pkg::SKIP_DASH;
        end else if (!p1 && w[0] && w[1] && !w[2] && !w[3]) begin
            add_en = 1'b1; add_sym = mtpd_pkg::SYM_DASH; add_skip = mtpd_pkg::SKIP_DASH;
        end else if (p1 && (w[4:0] == 5'b11111)) begin
            add_en = 1'b1; add_sym = mtpd_pkg::SYM_DASH; add_skip = mtpd_pkg::SKIP_DASH;
        end else if (p2 && !p1 && !w[0] && !w[1] && w[2] && !empty) begin
            add_en = 1'b1;
        end else if (p2 && !p1 && !w[0] && w[1] && !w[2] && !empty) begin
            add_en = 1'b1;
        end else if (!p1 && (w[4:0] == 5'b11111)) begin
            add_en = 1'b1;
        end else if (!p1 && w[0] && w[1] && !w[2] && w[3] && !top_heavy_reg) begin
            add_en = 1'b1; add_skip = mtpd_pkg::SKIP_SOFT_DOT;
        end else if (w[0] && w[1] && w[2] && w[3] && !w[4]) begin
            add_en = 1'b0;
        end else if (p1 && w[0] && w[1] && w[2] && !w[3]) begin
            add_en = 1'b0;
        end else if (p1 && w[0] && !w[1] && w[2] && w[3]) begin
            add_en = 1'b1; add_sym = mtpd_pkg::SYM_DASH; add_skip = mtpd_pkg::SKIP_DASH;
        end

        // A sixth symbol is dropped, but its skip count still applies.
        if (add_en) begin
            if (symbol_count_reg < CW'(NS)) begin
                symbol_store_next[symbol_count_reg] = add_sym;
                symbol_count_next = symbol_count_reg + 1'b1;
            end
            skip_left_next = add_skip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_window_reg     <= '0;
            prev_bit_reg        <= 1'b0;
            prev_prev_bit_reg   <= 1'b0;
            skip_left_reg       <= '0;
            symbol_count_reg    <= '0;
            message_started_reg <= 1'b0;
            last_was_space_reg  <= 1'b0;
            top_heavy_reg       <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                symbol_store_reg[i] <= mtpd_pkg::SYM_EMPTY;
            end
        end else if (step) begin
            tone_window_reg     <= tone_window_next;
            prev_bit_reg        <= prev_bit_next;
            prev_prev_bit_reg   <= prev_prev_bit_next;
            skip_left_reg       <= skip_left_next;
            symbol_count_reg    <= symbol_count_next;
            message_started_reg <= message_started_next;
            last_was_space_reg  <= last_was_space_next;
            top_heavy_reg       <= timing.top_heavy;
            symbol_store_reg    <= symbol_store_next;
        end
    end

endmodule

/* design/mtpd_checker.sv */
// Port-level checks of the Morse tone-period decoder, bound to its top level.
module mtpd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mtpd_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [mtpd_pkg::M_TUSER_W-1:0]    m_tuser
);

    logic out_fire;
    logic last_had_char_reg;
    logic last_space_reg;

    assign out_fire = m_tvalid && m_tready;

    // Remember what the previous result item and the previous character were.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_had_char_reg <= 1'b0;
            last_space_reg    <= 1'b0;
        end else if (out_fire) begin
            last_had_char_reg <= m_tuser[0];
            if (m_tuser[0]) begin
                last_space_reg <= (m_tdata[6:0] == mtpd_pkg::CHAR_SPACE);
            end
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_code_matches_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[6:0] != mtpd_pkg::CHAR_NONE)))
        else $error("char_code does not agree with char_valid");

    // Every emitted character sets a skip count, so two results in a row never both carry one.
    a_no_adjacent_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && last_had_char_reg |-> !m_tuser[0])
        else $error("characters in two consecutive result items");

    a_single_space: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && m_tuser[0] && last_space_reg |-> m_tdata[6:0] != mtpd_pkg::CHAR_SPACE)
        else $error("two spaces without a letter between them");

endmodule

bind morse_tone_period_decoder mtpd_checker u_mtpd_checker (.*);
